>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the page replacement unit.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> src/mfu_pkg.sv
// Package of the MFU page replacement unit: field widths, parameter defaults,
// and the command/status structs between controller and datapath. No dependencies.
package mfu_pkg;

    localparam int FRAMES_DEF     = 16;
    localparam int PAGE_BITS_DEF  = 12;
    localparam int COUNT_BITS_DEF = 16;

    localparam int PAGE_W  = 12;   // page_number and victim_page port width
    localparam int SLOT_W  = 5;    // slots_in_use register width
    localparam int TOTAL_W = 32;   // fault_total width
    localparam int STAMP_W = 32;   // insertion stamp / request index width

    localparam logic [SLOT_W-1:0] SLOT_RESET = 5'd16;

    typedef struct packed {
        logic capture;     // latch the accepted page
        logic lookup_rd;   // read the RAM entry of the matching frame
        logic fill;        // load the page into the lowest free frame, finish
        logic scan_start;  // clear the victim search
        logic scan_step;   // read one frame for the victim search
        logic hit_upd;     // write back the bumped count, finish
        logic repl;        // overwrite the victim frame, finish
    } t_cmd;

    typedef struct packed {
        logic hit;         // page matches a valid frame
        logic can_fill;    // room under the slot limit and a free frame
        logic scan_last;   // search is reading its last frame
        logic out_free;    // output register can take a result
    } t_stat;

endpackage

>>> src/mfu_if.sv
// Handshake channels of the page replacement unit: request and response.
// Depends on mfu_pkg for the payload widths.
interface mfu_req_if;
    import mfu_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface mfu_rsp_if;
    import mfu_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic               replaced;
    logic [PAGE_W-1:0]  victim_page;
    logic [TOTAL_W-1:0] fault_total;

    modport source (output valid, output hit, output replaced, output victim_page,
                    output fault_total, input ready);
    modport sink   (input valid, input hit, input replaced, input victim_page,
                    input fault_total, output ready);
endinterface

>>> src/mfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/mfu_ctrl.sv
// Controller of the page replacement unit: sequences lookup, fill, hit update
// and the victim search. Depends on mfu_pkg for the command and status structs.
module mfu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mfu_pkg::t_stat i_stat,
    output mfu_pkg::t_cmd  o_cmd
);
    import mfu_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MATCH    = 3'd1;
    localparam logic [2:0] S_HIT      = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_SCAN_END = 3'd4;
    localparam logic [2:0] S_REPL     = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       w_cmd;
    logic       w_ready;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                if (i_stat.hit) begin
                    w_cmd.lookup_rd = 1'b1;
                    n_state         = S_HIT;
                end else if (i_stat.can_fill) begin
                    // hold here until the output register drains
                    if (i_stat.out_free) begin
                        w_cmd.fill = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    w_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_HIT: begin
                if (i_stat.out_free) begin
                    w_cmd.hit_upd = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_SCAN: begin
                w_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                // last frame's data is compared in this cycle
                n_state = S_REPL;
            end
            S_REPL: begin
                if (i_stat.out_free) begin
                    w_cmd.repl = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = w_ready;
endmodule

>>> src/mfu_dpath.sv
// Datapath of the page replacement unit: frame tags and valid bits, the
// count/stamp RAM, victim search, counters and the output register.
// Depends on mfu_pkg and mfu_ram.
module mfu_dpath #(
    parameter int FRAMES     = mfu_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = mfu_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = mfu_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mfu_pkg::SLOT_W-1:0]   i_cfg_wdata,
    input  logic [mfu_pkg::PAGE_W-1:0]   i_page_number,
    input  mfu_pkg::t_cmd                i_cmd,
    output mfu_pkg::t_stat               o_stat,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_hit,
    output logic                         o_replaced,
    output logic [mfu_pkg::PAGE_W-1:0]   o_victim_page,
    output logic [mfu_pkg::TOTAL_W-1:0]  o_fault_total
);
    import mfu_pkg::*;

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_W = $clog2(FRAMES + 1);
    localparam int CMP_W  = (FILL_W > SLOT_W) ? FILL_W : SLOT_W;
    localparam int WIDE_W = (PAGE_BITS > PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int WORD_W = PAGE_BITS + COUNT_BITS + STAMP_W;

    // configuration and request
    logic [SLOT_W-1:0]    r_slots;
    logic [PAGE_BITS-1:0] r_page;

    // frame tags for the parallel lookup
    logic [PAGE_BITS-1:0] r_tag [FRAMES];
    logic [FRAMES-1:0]    r_valid;
    logic [FILL_W-1:0]    r_filled;
    logic [STAMP_W-1:0]   r_req_idx;
    logic [TOTAL_W-1:0]   r_faults;

    // victim search
    logic [IDX_W-1:0]      r_hit_idx;
    logic [IDX_W-1:0]      r_scan_idx;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_cmp_vld;
    logic                  r_best_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [COUNT_BITS-1:0] r_best_cnt;
    logic [STAMP_W-1:0]    r_best_stamp;
    logic [PAGE_BITS-1:0]  r_best_page;

    // output register
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_repl;
    logic [PAGE_W-1:0]  r_out_victim;
    logic [TOTAL_W-1:0] r_out_total;

    logic [WIDE_W-1:0]     w_in_wide;
    logic [PAGE_BITS-1:0]  w_in_tag;
    logic [WIDE_W-1:0]     w_vic_wide;
    logic [FRAMES-1:0]     w_hit_vec;
    logic                  w_hit_any;
    logic [IDX_W-1:0]      w_hit_idx;
    logic                  w_free_any;
    logic [IDX_W-1:0]      w_free_idx;
    logic [CMP_W-1:0]      w_cfg;
    logic [CMP_W-1:0]      w_lim;
    logic                  w_under;
    logic                  w_out_free;
    logic                  w_finish;
    logic                  w_miss_fin;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [WORD_W-1:0]     w_wdata;
    logic                  w_re;
    logic [IDX_W-1:0]      w_raddr;
    logic [WORD_W-1:0]     w_rdata;
    logic [PAGE_BITS-1:0]  w_rd_page;
    logic [COUNT_BITS-1:0] w_rd_cnt;
    logic [STAMP_W-1:0]    w_rd_stamp;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic                  w_better;
    logic [TOTAL_W-1:0]    w_faults_inc;

    assign w_in_wide  = WIDE_W'(i_page_number);
    assign w_in_tag   = w_in_wide[PAGE_BITS-1:0];
    assign w_vic_wide = WIDE_W'(r_best_page);

    // tag match and lowest free frame
    always_comb begin
        w_hit_vec  = '0;
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = 0; i < FRAMES; i++) begin
            w_hit_vec[i] = r_valid[i] && (r_tag[i] == r_page);
        end
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (w_hit_vec[i]) begin
                w_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
    end

    assign w_hit_any  = |w_hit_vec;
    assign w_free_any = ~&r_valid;

    // slot limit: zero acts as one, above FRAMES acts as FRAMES
    assign w_cfg   = CMP_W'(r_slots);
    assign w_lim   = (w_cfg == '0) ? CMP_W'(1) :
                     (w_cfg > CMP_W'(FRAMES)) ? CMP_W'(FRAMES) : w_cfg;
    assign w_under = CMP_W'(r_filled) < w_lim;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_miss_fin = i_cmd.fill || i_cmd.repl;
    assign w_finish   = w_miss_fin || i_cmd.hit_upd;

    // frame RAM: {page, count, stamp}
    assign w_rd_page  = w_rdata[WORD_W-1 -: PAGE_BITS];
    assign w_rd_cnt   = w_rdata[STAMP_W +: COUNT_BITS];
    assign w_rd_stamp = w_rdata[STAMP_W-1:0];
    assign w_cnt_inc  = (&w_rd_cnt) ? w_rd_cnt : w_rd_cnt + COUNT_BITS'(1);

    assign w_re    = i_cmd.lookup_rd || i_cmd.scan_step;
    assign w_raddr = i_cmd.scan_step ? r_scan_idx : w_hit_idx;
    assign w_we    = w_finish;
    assign w_waddr = i_cmd.fill ? w_free_idx : (i_cmd.hit_upd ? r_hit_idx : r_best_idx);
    assign w_wdata = i_cmd.hit_upd ? {w_rd_page, w_cnt_inc, w_rd_stamp}
                                   : {r_page, COUNT_BITS'(1), r_req_idx};

    mfu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAMES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // higher count wins, then earlier stamp; equal keeps the lower frame
    assign w_better = !r_best_found || (w_rd_cnt > r_best_cnt) ||
                      ((w_rd_cnt == r_best_cnt) && (w_rd_stamp < r_best_stamp));

    assign w_faults_inc = (&r_faults) ? r_faults : r_faults + TOTAL_W'(1);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots     <= SLOT_RESET;
            r_valid     <= '0;
            r_filled    <= '0;
            r_req_idx   <= '0;
            r_faults    <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slots <= i_cfg_wdata;
            end
            if (i_cmd.fill) begin
                r_valid[w_free_idx] <= 1'b1;
                r_filled            <= r_filled + FILL_W'(1);
            end
            if (w_finish && !(&r_req_idx)) begin
                r_req_idx <= r_req_idx + STAMP_W'(1);
            end
            if (w_miss_fin) begin
                r_faults <= w_faults_inc;
            end
            r_cmp_vld <= i_cmd.scan_step;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page <= w_in_tag;
        end
        if (i_cmd.fill) begin
            r_tag[w_free_idx] <= r_page;
        end
        if (i_cmd.repl) begin
            r_tag[r_best_idx] <= r_page;
        end
        if (i_cmd.lookup_rd) begin
            r_hit_idx <= w_hit_idx;
        end
        if (i_cmd.scan_start) begin
            r_scan_idx   <= '0;
            r_best_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        if (i_cmd.scan_step) begin
            r_cmp_idx <= r_scan_idx;
        end
        // skip frames never filled
        if (r_cmp_vld && r_valid[r_cmp_idx] && w_better) begin
            r_best_found <= 1'b1;
            r_best_idx   <= r_cmp_idx;
            r_best_cnt   <= w_rd_cnt;
            r_best_stamp <= w_rd_stamp;
            r_best_page  <= w_rd_page;
        end
        if (w_finish) begin
            r_out_hit    <= i_cmd.hit_upd;
            r_out_repl   <= i_cmd.repl;
            r_out_victim <= i_cmd.repl ? w_vic_wide[PAGE_W-1:0] : '0;
            r_out_total  <= w_miss_fin ? w_faults_inc : r_faults;
        end
    end

    assign o_stat.hit       = w_hit_any;
    assign o_stat.can_fill  = w_under && w_free_any;
    assign o_stat.scan_last = (r_scan_idx == IDX_W'(FRAMES - 1));
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_replaced    = r_out_repl;
    assign o_victim_page = r_out_victim;
    assign o_fault_total = r_out_total;
endmodule

>>> src/mfu_page_replacement_unit.sv
// Most-frequently-used page replacement unit. Each accepted page reference gives
// one response: hit, or a fault that fills a free frame or evicts the frame with
// the highest use count (ties to the oldest insertion, then the lowest frame).
// A fault into a free frame finishes soonest and a fault with eviction takes
// longest, because the victim search reads the count/stamp RAM one frame per
// cycle through its single read port. The response sits in an output register,
// so a new request is taken while the previous response waits. slots_in_use is
// written via i_cfg_we / i_cfg_wdata; the user must write it only while the unit
// is idle, which the block itself does not enforce. It resets to 16.
`include "assert_macros.svh"

module mfu_page_replacement_unit #(
    parameter int FRAMES     = mfu_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = mfu_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = mfu_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mfu_pkg::SLOT_W-1:0] i_cfg_wdata,
    mfu_req_if.sink                    i_req,
    mfu_rsp_if.source                  o_rsp
);
    import mfu_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    mfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mfu_dpath #(
        .FRAMES     (FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_page_number (i_req.page_number),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_hit         (o_rsp.hit),
        .o_replaced    (o_rsp.replaced),
        .o_victim_page (o_rsp.victim_page),
        .o_fault_total (o_rsp.fault_total)
    );

    assign i_req.ready = w_in_ready;

    // one reference in flight: no acceptance right after an acceptance
    `ASSERT_PROP(a_one_in_flight, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> !i_req.ready)
    // a reference finishes in exactly one way
    `ASSERT_PROP(a_one_finish, i_clk, i_rst_n, $onehot0({w_cmd.fill, w_cmd.hit_upd, w_cmd.repl}))
    // never finish into an occupied output register
    `ASSERT_NEVER(a_no_overrun, i_clk, i_rst_n, (w_cmd.fill || w_cmd.hit_upd || w_cmd.repl) && !w_stat.out_free)
    // an eviction is always a fault
    `ASSERT_NEVER(a_repl_is_fault, i_clk, i_rst_n, o_rsp.valid && o_rsp.replaced && o_rsp.hit)
endmodule

>>> verif/mfu_page_replacement_unit_test.sv
// Self-checking testbench of mfu_page_replacement_unit: a directed table and random
// phases over several slot limits, checked by a local predictor.
// Depends on mfu_pkg and the mfu_req_if / mfu_rsp_if channels.
module mfu_page_replacement_unit_test;
    import mfu_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int FRAMES        = FRAMES_DEF;
    localparam int COUNT_W       = COUNT_BITS_DEF;
    localparam int SETTLE_CYCLES = FRAMES + 8;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 140;
    localparam longint TIMEOUT   = 64'd20_000_000;

    typedef struct packed {
        logic               hit;
        logic               replaced;
        logic [PAGE_W-1:0]  victim_page;
        logic [TOTAL_W-1:0] fault_total;
    } t_page_result;

    typedef enum logic {ROW_REF, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [PAGE_W-1:0]  page;
        logic [SLOT_W-1:0]  slots;
        logic               typed;
        t_page_result       want;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 24;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_REF, 12'h000, 5'd0,  1'b1, '{1'b0, 1'b0, 12'h000, 32'd1}},
        '{ROW_REF, 12'hFFF, 5'd0,  1'b1, '{1'b0, 1'b0, 12'h000, 32'd2}},
        '{ROW_REF, 12'h000, 5'd0,  1'b1, '{1'b1, 1'b0, 12'h000, 32'd2}},
        '{ROW_REF, 12'h000, 5'd0,  1'b1, '{1'b1, 1'b0, 12'h000, 32'd2}},
        '{ROW_REF, 12'hFFF, 5'd0,  1'b1, '{1'b1, 1'b0, 12'h000, 32'd2}},
        // limit drops below the filled count: evict the busiest page
        '{ROW_CFG, 12'h000, 5'd1,  1'b0, '0},
        '{ROW_REF, 12'h555, 5'd0,  1'b1, '{1'b0, 1'b1, 12'h000, 32'd3}},
        '{ROW_REF, 12'hAAA, 5'd0,  1'b1, '{1'b0, 1'b1, 12'hFFF, 32'd4}},
        '{ROW_REF, 12'hAAA, 5'd0,  1'b0, '0},
        // zero limit acts as one
        '{ROW_CFG, 12'h000, 5'd0,  1'b0, '0},
        '{ROW_REF, 12'h123, 5'd0,  1'b0, '0},
        // equal counts: the oldest insertion goes
        '{ROW_CFG, 12'h000, 5'd2,  1'b0, '0},
        '{ROW_REF, 12'h7FF, 5'd0,  1'b0, '0},
        '{ROW_REF, 12'h800, 5'd0,  1'b0, '0},
        // limit above the frame count acts as the frame count
        '{ROW_CFG, 12'h000, 5'd17, 1'b0, '0},
        '{ROW_REF, 12'h001, 5'd0,  1'b0, '0},
        '{ROW_REF, 12'h002, 5'd0,  1'b0, '0},
        '{ROW_REF, 12'hFFE, 5'd0,  1'b0, '0},
        '{ROW_REF, 12'h001, 5'd0,  1'b0, '0},
        '{ROW_CFG, 12'h000, 5'd31, 1'b0, '0},
        '{ROW_REF, 12'h800, 5'd0,  1'b0, '0},
        '{ROW_REF, 12'hF0F, 5'd0,  1'b0, '0},
        '{ROW_REF, 12'h000, 5'd0,  1'b0, '0},
        '{ROW_REF, 12'h7FF, 5'd0,  1'b0, '0}
    };

    localparam logic [SLOT_W-1:0] PHASE_SLOTS [PHASES] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9, 5'd17, 5'd2, 5'd7
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [SLOT_W-1:0] i_cfg_wdata;

    mfu_req_if req_ch ();
    mfu_rsp_if rsp_ch ();

    mfu_page_replacement_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predicted frame table
    logic [PAGE_W-1:0]  frame_tag   [FRAMES];
    logic               frame_used  [FRAMES];
    logic [COUNT_W-1:0] frame_uses  [FRAMES];
    logic [STAMP_W-1:0] frame_birth [FRAMES];
    logic [STAMP_W-1:0] ref_index;
    logic [SLOT_W-1:0]  filled_count;
    logic [TOTAL_W-1:0] fault_count;
    logic [SLOT_W-1:0]  slot_limit;

    t_page_result pending_results [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    function automatic t_page_result apply_reference(input logic [PAGE_W-1:0] page);
        t_page_result res;
        int slot;
        int best;
        int unsigned lim;
        res  = '0;
        slot = -1;
        lim  = (slot_limit == 0) ? 1 : (slot_limit > FRAMES) ? FRAMES : slot_limit;
        for (int f = 0; f < FRAMES; f++)
            if (slot < 0 && frame_used[f] && frame_tag[f] == page) slot = f;
        if (slot >= 0) begin
            res.hit = 1'b1;
            if (frame_uses[slot] != '1) frame_uses[slot]++;
        end else begin
            if (filled_count < lim) begin
                for (int f = 0; f < FRAMES; f++)
                    if (slot < 0 && !frame_used[f]) slot = f;
                if (slot >= 0) filled_count++;
            end
            if (slot < 0) begin
                best = -1;
                for (int f = 0; f < FRAMES; f++)
                    if (frame_used[f] && (best < 0 || frame_uses[f] > frame_uses[best] ||
                        (frame_uses[f] == frame_uses[best] &&
                         frame_birth[f] < frame_birth[best])))
                        best = f;
                slot = best;
                if (slot >= 0) begin
                    res.replaced    = 1'b1;
                    res.victim_page = frame_tag[slot];
                end
            end
            if (slot >= 0) begin
                frame_tag[slot]   = page;
                frame_used[slot]  = 1'b1;
                frame_uses[slot]  = 1;
                frame_birth[slot] = ref_index;
            end
            if (fault_count != '1) fault_count++;
        end
        if (ref_index != '1) ref_index++;
        res.fault_total = fault_count;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // one reference: random gap, hold valid until accepted, then record the expected result
    task automatic send_page(input logic [PAGE_W-1:0] page, input logic typed,
                             input t_page_result want);
        t_page_result predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.page_number <= page;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = apply_reference(page);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_slots(input logic [SLOT_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        slot_limit = value;
    endtask

    always @(negedge i_clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge i_clk) begin : rsp_monitor
        t_page_result want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("response transaction with no reference outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, rsp_ch.hit);
                check_field("replaced", want.replaced, rsp_ch.replaced);
                check_field("victim_page", want.victim_page, rsp_ch.victim_page);
                check_field("fault_total", want.fault_total, rsp_ch.fault_total);
            end
        end
    end

    initial begin : stimulus
        logic [PAGE_W-1:0] page_pool [$];
        logic [PAGE_W-1:0] next_page;
        logic [SLOT_W-1:0] cfg_value;
        int unsigned eff_limit;
        int unsigned roll;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = SLOT_RESET;
        req_ch.valid       = 1'b0;
        req_ch.page_number = '0;
        rsp_ch.ready       = 1'b0;
        foreach (frame_used[f]) begin
            frame_used[f] = 1'b0;
            frame_uses[f] = '0;
        end
        ref_index    = '0;
        filled_count = '0;
        fault_count  = '0;
        slot_limit   = SLOT_RESET;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 80;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_slots(DIRECTED[i].slots);
            else
                send_page(DIRECTED[i].page, DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p / 3)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 80;
                end
                1: begin
                    send_idle_pct = 80;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            cfg_value = (p == PHASES - 1) ? SLOT_W'($urandom_range(0, 31)) : PHASE_SLOTS[p];
            write_slots(cfg_value);
            eff_limit = (cfg_value == 0) ? 1 : (cfg_value > FRAMES) ? FRAMES : cfg_value;
            // a working set a little larger than the limit mixes hits and evictions
            page_pool.delete();
            repeat (eff_limit + $urandom_range(1, 6))
                page_pool.push_back(PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    next_page = page_pool[$urandom_range(0, page_pool.size() - 1)];
                else if (roll < 95)
                    next_page = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
                else if (roll < 97)
                    next_page = '0;
                else if (roll < 99)
                    next_page = '1;
                else
                    next_page = PAGE_W'(1) << $urandom_range(0, PAGE_W - 1);
                send_page(next_page, 1'b0, '0);
            end
        end

        drain();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
